/* rtl/core/pkdet_pkg.sv */
// Shared types and constants of the per-key debounce event tracker.
package pkdet_pkg;

	localparam int KEY_W   = 5;
	localparam int TIME_W  = 32;
	localparam int DEB_W   = 10;
	localparam int MASK_W  = 16;
	localparam int IN_W    = 40;
	localparam int OUT_W   = 56;

	localparam logic [DEB_W-1:0] DEB_RESET = 10'd20;

	localparam logic EV_PRESS   = 1'b0;
	localparam logic EV_RELEASE = 1'b1;

	typedef enum logic [1:0] {
		PH_IDLE        = 2'd0,
		PH_DEB_PRESS   = 2'd1,
		PH_PRESSED     = 2'd2,
		PH_DEB_RELEASE = 2'd3
	} phase_t;

endpackage

/* rtl/core/per_key_debounce_event_tracker.sv */
// Per-key debounce tracker: raw key samples in, confirmed press and release events out.
//
// Input requests on s_*: one raw sample per request (key id, contact level, time in ms).
// Output requests on m_*: one press or release event, with the time of the confirming
// sample and the debounced pressed mask after the change. Most samples give no event.
// cfg_we/cfg_wdata set the debounce time in ms; write it only while the block is idle.
// Each key's phase and phase entry time live in two small synchronous memories. A sample
// reads its key's entry at the accepting edge, is evaluated in the next cycle and written
// back when it leaves that stage, which also loads any event it raises into the output
// register. A sample of the same key in the very next cycle takes the written-back state
// through a bypass register, so one sample per cycle is sustained for any key order, if
// no event stalls. Key ids of 0 or above KEYS are taken and dropped without an event.
// Reset puts every key in the idle phase (per-key valid bits, no clearing pass), clears
// the pressed mask and loads a debounce time of 20 ms.
// While the receiver stalls, a waiting event holds in the output register; the block
// keeps taking samples until an evaluated sample needs that register, then it stalls.
module per_key_debounce_event_tracker #(
	parameter int KEYS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// key_id[4:0], raw_pressed[5], now_ms[37:6], zero fill above
	input  logic [pkdet_pkg::IN_W-1:0]  s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// event_key[4:0], event_time[36:5], stable_mask[52:37], zero fill above
	output logic [pkdet_pkg::OUT_W-1:0] m_tdata,
	// event_kind[0]
	output logic                        m_tuser,
	input  logic                        cfg_we,
	input  logic [pkdet_pkg::DEB_W-1:0] cfg_wdata
);
	import pkdet_pkg::*;

	localparam int IW = (KEYS > 1) ? $clog2(KEYS) : 1;
	localparam int MW = (KEYS > MASK_W) ? KEYS : MASK_W;

	// Key state memories.
	phase_t            phase_mem [KEYS];
	logic [TIME_W-1:0] time_mem  [KEYS];
	logic [KEYS-1:0]   phase_vld_q;

	logic [KEYS-1:0]   mask_q;
	logic [DEB_W-1:0]  dbt_q;

	// Evaluation stage.
	logic              vld_s1;
	logic              ok_s1;
	logic [KEY_W-1:0]  key_s1;
	logic [IW-1:0]     idx_s1;
	logic              raw_s1;
	logic [TIME_W-1:0] now_s1;
	phase_t            rd_phase_s1;
	logic [TIME_W-1:0] rd_time_s1;
	logic              fwd_s1;
	phase_t            fwd_phase_s1;
	logic [TIME_W-1:0] fwd_time_s1;

	// Output register.
	logic              out_vld_q;
	logic              out_kind_q;
	logic [KEY_W-1:0]  out_key_q;
	logic [TIME_W-1:0] out_time_q;
	logic [MASK_W-1:0] out_mask_q;

	logic [KEY_W-1:0]  in_key;
	logic              in_ok;
	logic [IW-1:0]     in_idx;
	logic              acc;

	phase_t            cur_phase;
	logic [TIME_W-1:0] cur_time;
	logic              held;
	phase_t            nxt_phase;
	logic [TIME_W-1:0] nxt_time;
	logic              res_valid;
	logic              res_kind;
	logic              out_free;
	logic              s1_done;
	logic              wr_en;
	logic [KEYS-1:0]   key_bit;
	logic [KEYS-1:0]   mask_nxt;
	logic [MW-1:0]     mask_ext;

	assign in_key = s_tdata[KEY_W-1:0];
	assign in_ok  = (in_key != '0) && (in_key <= KEY_W'(KEYS));
	assign in_idx = IW'(in_key - KEY_W'(1));

	assign cur_phase = fwd_s1 ? fwd_phase_s1 :
		(phase_vld_q[idx_s1] ? rd_phase_s1 : PH_IDLE);
	assign cur_time  = fwd_s1 ? fwd_time_s1 : rd_time_s1;
	assign held      = (now_s1 - cur_time) >= TIME_W'(dbt_q);

	// Next phase and entry time of the sampled key.
	always_comb begin
		nxt_phase = cur_phase;
		nxt_time  = cur_time;
		case (cur_phase)
			PH_IDLE: begin
				if (raw_s1) begin
					nxt_phase = PH_DEB_PRESS;
					nxt_time  = now_s1;
				end
			end
			PH_DEB_PRESS: begin
				if (!raw_s1) begin
					nxt_phase = PH_IDLE;
				end else if (held) begin
					nxt_phase = PH_PRESSED;
				end
			end
			PH_PRESSED: begin
				if (!raw_s1) begin
					nxt_phase = PH_DEB_RELEASE;
					nxt_time  = now_s1;
				end
			end
			PH_DEB_RELEASE: begin
				if (raw_s1) begin
					nxt_phase = PH_PRESSED;
					nxt_time  = now_s1;
				end else if (held) begin
					nxt_phase = PH_IDLE;
				end
			end
			default: begin
				nxt_phase = PH_IDLE;
			end
		endcase
	end

	// Event decision of the sampled key.
	always_comb begin
		res_valid = 1'b0;
		res_kind  = EV_PRESS;
		case (cur_phase)
			PH_DEB_PRESS: begin
				res_valid = ok_s1 && raw_s1 && held;
				res_kind  = EV_PRESS;
			end
			PH_DEB_RELEASE: begin
				res_valid = ok_s1 && !raw_s1 && held;
				res_kind  = EV_RELEASE;
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	assign out_free = !out_vld_q || m_tready;
	assign s1_done  = vld_s1 && (!res_valid || out_free);
	assign wr_en    = s1_done && ok_s1;
	assign s_tready = !vld_s1 || s1_done;
	assign acc      = s_tvalid && s_tready;

	assign key_bit  = KEYS'(1) << idx_s1;
	assign mask_nxt = (res_kind == EV_PRESS) ? (mask_q | key_bit) : (mask_q & ~key_bit);
	assign mask_ext = MW'(mask_nxt);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			phase_mem[idx_s1] <= nxt_phase;
			time_mem[idx_s1]  <= nxt_time;
		end
		if (acc) begin
			rd_phase_s1 <= phase_mem[in_idx];
			rd_time_s1  <= time_mem[in_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			key_s1       <= in_key;
			idx_s1       <= in_idx;
			raw_s1       <= s_tdata[KEY_W];
			now_s1       <= s_tdata[KEY_W+TIME_W:KEY_W+1];
			fwd_phase_s1 <= nxt_phase;
			fwd_time_s1  <= nxt_time;
		end
		if (s1_done && res_valid) begin
			out_kind_q <= res_kind;
			out_key_q  <= key_s1;
			out_time_q <= now_s1;
			out_mask_q <= mask_ext[MASK_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			ok_s1       <= 1'b0;
			fwd_s1      <= 1'b0;
			phase_vld_q <= '0;
			mask_q      <= '0;
			dbt_q       <= DEB_RESET;
			out_vld_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				dbt_q <= cfg_wdata;
			end
			if (acc) begin
				vld_s1 <= 1'b1;
				ok_s1  <= in_ok;
				// The entry being written back now is newer than what the memory returns.
				fwd_s1 <= wr_en && (idx_s1 == in_idx);
			end else if (s1_done) begin
				vld_s1 <= 1'b0;
				ok_s1  <= 1'b0;
				fwd_s1 <= 1'b0;
			end
			if (wr_en) begin
				phase_vld_q[idx_s1] <= 1'b1;
				if (res_valid) begin
					mask_q <= mask_nxt;
				end
			end
			if (s1_done && res_valid) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_kind_q;
	assign m_tdata  = {{(OUT_W - KEY_W - TIME_W - MASK_W){1'b0}},
		out_mask_q, out_time_q, out_key_q};

`ifndef SYNTH
	a_fwd_needs_stage: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 |-> vld_s1)
		else $error("bypass flag set with an empty evaluation stage");

	a_no_take_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !s1_done) |-> !s_tready)
		else $error("request taken while the evaluation stage is stalled");

	a_event_from_debounce: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (cur_phase == PH_DEB_PRESS || cur_phase == PH_DEB_RELEASE))
		else $error("event raised outside a debounce phase");

	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !m_tready) |=> (out_vld_q && $stable(out_key_q) &&
		$stable(out_time_q) && $stable(out_mask_q) && $stable(out_kind_q)))
		else $error("waiting event overwritten");
`endif

endmodule

/* dv/per_key_debounce_event_tracker_tb.sv */
// Testbench for the per-key debounce event tracker: directed and random key samples, events checked.
module per_key_debounce_event_tracker_tb;
	import pkdet_pkg::*;

	localparam int KEYS       = 16;
	localparam int LIMIT      = 200000;
	localparam int PIPE_DRAIN = 4;

	typedef struct {
		logic              kind;
		logic [KEY_W-1:0]  key;
		logic [TIME_W-1:0] stamp;
		logic [MASK_W-1:0] mask;
	} key_event_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata;
	logic              m_tvalid;
	logic              m_tready;
	logic [OUT_W-1:0]  m_tdata;
	logic              m_tuser;
	logic              cfg_we;
	logic [DEB_W-1:0]  cfg_wdata;

	// Predicted state of every key.
	phase_t            key_state [KEYS];
	logic [TIME_W-1:0] entry_ms [KEYS];
	logic [MASK_W-1:0] stable_keys;
	logic [DEB_W-1:0]  hold_ms;

	key_event_t        pending_events [$];
	key_event_t        head;
	bit                held [1:KEYS];
	bit                idle_on;
	int                failures;

	per_key_debounce_event_tracker #(
		.KEYS(KEYS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic bit track_sample(input logic [KEY_W-1:0] key, input logic raw,
			input logic [TIME_W-1:0] now, output key_event_t ev);
		logic [TIME_W-1:0] elapsed;
		int idx;
		bit fired;
		fired = 1'b0;
		ev.kind = EV_PRESS;
		ev.key = key;
		ev.stamp = now;
		ev.mask = '0;
		if (key == 0 || key > KEYS)
			return 1'b0;
		idx = int'(key) - 1;
		elapsed = now - entry_ms[idx];
		case (key_state[idx])
			PH_IDLE: begin
				if (raw) begin
					key_state[idx] = PH_DEB_PRESS;
					entry_ms[idx] = now;
				end
			end
			PH_DEB_PRESS: begin
				if (!raw) begin
					key_state[idx] = PH_IDLE;
				end else if (elapsed >= hold_ms) begin
					key_state[idx] = PH_PRESSED;
					stable_keys[idx] = 1'b1;
					ev.kind = EV_PRESS;
					fired = 1'b1;
				end
			end
			PH_PRESSED: begin
				if (!raw) begin
					key_state[idx] = PH_DEB_RELEASE;
					entry_ms[idx] = now;
				end
			end
			default: begin
				if (raw) begin
					// A bounce back to the closed level restarts the pressed phase.
					key_state[idx] = PH_PRESSED;
					entry_ms[idx] = now;
				end else if (elapsed >= hold_ms) begin
					key_state[idx] = PH_IDLE;
					stable_keys[idx] = 1'b0;
					ev.kind = EV_RELEASE;
					fired = 1'b1;
				end
			end
		endcase
		ev.mask = stable_keys;
		return fired;
	endfunction

	// Called at a falling edge; returns at the falling edge after the request is taken.
	task automatic send_sample(input logic [KEY_W-1:0] key, input logic raw,
			input logic [TIME_W-1:0] now);
		key_event_t ev;
		int gap;
		gap = 0;
		if (idle_on && $urandom_range(0, 4) == 0)
			gap = $urandom_range(1, 14);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata <= {2'b00, now, raw, key};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		if (track_sample(key, raw, now, ev))
			pending_events.insert(pending_events.size(), ev);
		@(negedge clk);
	endtask

	// Waits until every predicted event has come out and the pipeline is empty.
	task automatic settle();
		int waited;
		waited = 0;
		s_tvalid <= 1'b0;
		while (pending_events.size() != 0 && waited < 3000) begin
			@(negedge clk);
			waited++;
		end
		if (pending_events.size() != 0) begin
			$display("%0t: %0d expected events never arrived", $time, pending_events.size());
			failures++;
			pending_events.delete();
		end
		repeat (PIPE_DRAIN) @(negedge clk);
	endtask

	task automatic write_debounce(input logic [DEB_W-1:0] value);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		hold_ms = value;
	endtask

	task automatic test_basic_press_release();
		send_sample(5'd1, 1'b1, 32'd100);
		send_sample(5'd1, 1'b1, 32'd119);
		send_sample(5'd1, 1'b1, 32'd120);
		send_sample(5'd1, 1'b0, 32'd130);
		send_sample(5'd1, 1'b0, 32'd150);
	endtask

	task automatic test_ignored_keys();
		send_sample(5'd0, 1'b1, 32'd0);
		send_sample(5'd17, 1'b1, 32'd500);
		send_sample(5'd31, 1'b1, 32'hFFFF_FFFF);
	endtask

	task automatic test_bounce();
		send_sample(5'd16, 1'b1, 32'd0);
		send_sample(5'd2, 1'b1, 32'd0);
		send_sample(5'd2, 1'b0, 32'd5);
		send_sample(5'd2, 1'b1, 32'd6);
		send_sample(5'd16, 1'b1, 32'd20);
		send_sample(5'd2, 1'b1, 32'd26);
		send_sample(5'd2, 1'b0, 32'd30);
		send_sample(5'd2, 1'b1, 32'd35);
		send_sample(5'd2, 1'b0, 32'd40);
		send_sample(5'd2, 1'b0, 32'd59);
		send_sample(5'd2, 1'b0, 32'd60);
	endtask

	task automatic test_zero_debounce();
		write_debounce(10'd0);
		send_sample(5'd3, 1'b1, 32'd500);
		send_sample(5'd3, 1'b1, 32'd500);
		send_sample(5'd3, 1'b0, 32'd500);
		send_sample(5'd3, 1'b0, 32'd500);
	endtask

	// Longest debounce time, with the elapsed time crossing the wrap of the ms counter.
	task automatic test_long_debounce_wrap();
		write_debounce(10'd1023);
		send_sample(5'd5, 1'b1, 32'hFFFF_FE00);
		send_sample(5'd16, 1'b0, 32'hFFFF_FFFF);
		send_sample(5'd5, 1'b1, 32'h0000_01FE);
		send_sample(5'd5, 1'b1, 32'h0000_01FF);
		send_sample(5'd16, 1'b0, 32'h0000_03FE);
	endtask

	// Mostly steady key levels with occasional bounces, plus some fully random samples.
	task automatic test_random_traffic(input int count, input logic [TIME_W-1:0] start_ms);
		logic [TIME_W-1:0] clock_ms;
		logic [KEY_W-1:0]  key;
		logic [KEY_W-1:0]  noise_key;
		logic [TIME_W-1:0] noise_ms;
		logic              raw;
		int step;
		clock_ms = start_ms;
		key = 5'd1;
		step = hold_ms / 3 + 3;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 9) == 0) begin
				noise_key = KEY_W'($urandom_range(0, 31));
				noise_ms = $urandom;
				raw = 1'($urandom_range(0, 1));
				send_sample(noise_key, raw, noise_ms);
			end else begin
				if ($urandom_range(0, 3) != 0)
					key = KEY_W'($urandom_range(1, KEYS));
				if ($urandom_range(0, 7) == 0)
					held[key] = !held[key];
				raw = held[key];
				if ($urandom_range(0, 9) == 0)
					raw = !raw;
				clock_ms += $urandom_range(0, step);
				send_sample(key, raw, clock_ms);
			end
		end
	endtask

	// Result receiver: stalls in random bursts while idling is enabled.
	initial begin
		int stall;
		stall = 0;
		m_tready <= 1'b0;
		forever begin
			@(negedge clk);
			if (!idle_on) begin
				stall = 0;
				m_tready <= 1'b1;
			end else if (stall > 0) begin
				stall--;
				m_tready <= 1'b0;
			end else if ($urandom_range(0, 7) == 0) begin
				stall = $urandom_range(1, 14) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_events.size() == 0) begin
				$display("%0t: unexpected event, kind %0d key %0d time %h mask %h", $time,
					m_tuser, m_tdata[4:0], m_tdata[36:5], m_tdata[52:37]);
				failures++;
			end else begin
				head = pending_events.pop_front();
				if (m_tuser !== head.kind) begin
					$display("%0t: event_kind expected %0d, got %0d", $time, head.kind, m_tuser);
					failures++;
				end
				if (m_tdata[4:0] !== head.key) begin
					$display("%0t: event_key expected %0d, got %0d", $time, head.key,
						m_tdata[4:0]);
					failures++;
				end
				if (m_tdata[36:5] !== head.stamp) begin
					$display("%0t: event_time expected %h, got %h", $time, head.stamp,
						m_tdata[36:5]);
					failures++;
				end
				if (m_tdata[52:37] !== head.mask) begin
					$display("%0t: stable_mask expected %h, got %h", $time, head.mask,
						m_tdata[52:37]);
					failures++;
				end
			end
		end
	end

	initial begin
		repeat (LIMIT) @(posedge clk);
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		failures = 0;
		idle_on = 1'b1;
		for (int k = 0; k < KEYS; k++) begin
			key_state[k] = PH_IDLE;
			entry_ms[k] = '0;
		end
		for (int k = 1; k <= KEYS; k++)
			held[k] = 1'b0;
		stable_keys = '0;
		hold_ms = DEB_RESET;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_basic_press_release();
		test_ignored_keys();
		test_bounce();
		test_zero_debounce();
		test_long_debounce_wrap();

		write_debounce(10'd0);
		test_random_traffic(140, $urandom);
		write_debounce(10'd1023);
		test_random_traffic(170, 32'hFFFF_F000);
		write_debounce(DEB_W'($urandom_range(2, 60)));
		idle_on = 1'b0;
		test_random_traffic(170, $urandom);
		write_debounce(10'd1);
		idle_on = 1'b1;
		test_random_traffic(170, $urandom);
		write_debounce(DEB_W'($urandom_range(0, 1023)));
		test_random_traffic(100, $urandom);
		write_debounce(DEB_RESET);
		idle_on = 1'b0;
		test_random_traffic(100, $urandom);

		settle();
		repeat (10) @(negedge clk);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

/* per_key_debounce_event_tracker.f */
rtl/core/pkdet_pkg.sv
rtl/core/per_key_debounce_event_tracker.sv
dv/per_key_debounce_event_tracker_tb.sv
